[design/ttag_pkg.sv]
// ----------------------------------------------------------------------------
// ttag_pkg
// Shared widths, register map and reset values of the transpose address
// generator.
// ----------------------------------------------------------------------------
package ttag_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_AXES_DEFAULT      = 4;
  localparam int ELEMENT_WIDTH_DEFAULT = 32;

  // Field widths
  localparam int DIGIT_W         = 8;
  localparam int ELEMENT_FIELD_W = 32;
  localparam int ADDR_W          = 32;
  localparam int S_TDATA_W       = 32;
  localparam int M_TDATA_W       = 64;

  // Configuration port
  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  typedef enum logic [1:0] {
    REG_AXIS_COUNT = 2'd0,
    REG_DIM_SIZES  = 2'd1,
    REG_AXIS_ORDER = 2'd2
  } cfg_reg_t;

  // Register reset values (identity order, one axis of size one)
  localparam logic [2:0]  AXIS_COUNT_RESET = 3'd1;
  localparam logic [31:0] DIM_SIZES_RESET  = 32'd0;
  localparam logic [7:0]  AXIS_ORDER_RESET = 8'd228;

endpackage

[design/tensor_transpose_address_gen.sv]
// ----------------------------------------------------------------------------
// tensor_transpose_address_gen
// Tags each element of a source tensor with its address after an axis
// permutation.
// ----------------------------------------------------------------------------
// Usage:
//   Elements arrive on the s_ side in source order, axis 0 fastest. Each
//   request carries the element in s_tdata and a restart flag in s_tuser that
//   clears the source index before that element. Every element leaves on the
//   m_ side with its destination address, the element value, tlast on the
//   final element of the tensor and an order-error flag in tuser.
//   Throughput is one element per cycle while s_tready is high. Each accepted
//   element loads the product register (digit times stride per axis), which in
//   turn loads the result register (sum of products).
//   Strides are derived from the registers by a chain of prefix-product
//   registers, one per axis, so after reset and after every register write
//   s_tready stays low while the stride table reloads.
//   Reset returns the registers to one axis of size one with identity order,
//   clears the source index and empties both pipeline stages.
//   When the receiver stalls, the result register holds its request and the
//   product stage still takes one more element; after that s_tready drops
//   until m_tready returns.
// ----------------------------------------------------------------------------
module tensor_transpose_address_gen
  import ttag_pkg::*;
#(
  parameter int MAX_AXES      = MAX_AXES_DEFAULT,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
) (
  input  logic                 clk,
  input  logic                 rst,
  // input stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] element
  input  logic [0:0]           s_tuser,   // [0] restart
  // output stream
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [M_TDATA_W-1:0] m_tdata,   // [31:0] dest_address, [63:32] value
  output logic                 m_tlast,
  output logic [0:0]           m_tuser,   // [0] order_error
  // configuration
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [PADDR_W-1:0]   paddr,
  input  logic [PDATA_W-1:0]   pwdata,
  output logic [PDATA_W-1:0]   prdata,
  output logic                 pready
);

  // Largest stride: product of MAX_AXES-1 sizes of up to 256 each
  localparam int STRIDE_W = DIGIT_W * (MAX_AXES - 1) + 1;
  localparam int TERM_W   = STRIDE_W + DIGIT_W;
  localparam int VALUE_W  = (ELEMENT_WIDTH < ELEMENT_FIELD_W) ? ELEMENT_WIDTH
                                                              : ELEMENT_FIELD_W;
  localparam int SETTLE_W = $clog2(MAX_AXES + 1);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [2:0]  axis_count;
  logic [31:0] dim_sizes;
  logic [7:0]  axis_order;
  logic        cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      axis_count <= AXIS_COUNT_RESET;
      dim_sizes  <= DIM_SIZES_RESET;
      axis_order <= AXIS_ORDER_RESET;
    end else if (cfg_write) begin
      unique case (paddr[3:2])
        REG_AXIS_COUNT: axis_count <= pwdata[2:0];
        REG_DIM_SIZES:  dim_sizes  <= pwdata;
        REG_AXIS_ORDER: axis_order <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_AXIS_COUNT: prdata = {29'd0, axis_count};
      REG_DIM_SIZES:  prdata = dim_sizes;
      REG_AXIS_ORDER: prdata = {24'd0, axis_order};
      default:        prdata = '0;
    endcase
  end

  // Axes in use: zero counts as one, anything above MAX_AXES as MAX_AXES
  logic [2:0] n_used;
  always_comb begin
    if (axis_count == 3'd0) begin
      n_used = 3'd1;
    end else if (axis_count > 3'(MAX_AXES)) begin
      n_used = 3'(MAX_AXES);
    end else begin
      n_used = axis_count;
    end
  end

  // --------------------------------------------------------------------------
  // Stride table
  // --------------------------------------------------------------------------
  // Size of the axis at each destination position; unused axes count as one.
  logic [DIGIT_W:0] pos_size [MAX_AXES];
  always_comb begin
    for (int j = 0; j < MAX_AXES; j++) begin
      pos_size[j] = (DIGIT_W + 1)'(1);
      for (int k = 0; k < MAX_AXES; k++) begin
        if (axis_order[2*j +: 2] == 2'(k) && 3'(k) < n_used) begin
          pos_size[j] = {1'b0, dim_sizes[DIGIT_W*k +: DIGIT_W]} + (DIGIT_W + 1)'(1);
        end
      end
    end
  end

  // prefix[j]: product of the sizes at positions below j, one multiply a stage
  logic [STRIDE_W-1:0] prefix      [MAX_AXES];
  logic [STRIDE_W-1:0] prefix_next [MAX_AXES];
  always_comb begin
    logic [STRIDE_W+DIGIT_W:0] prod;
    prod = '0;
    prefix_next[0] = STRIDE_W'(1);
    for (int j = 1; j < MAX_AXES; j++) begin
      prod = (STRIDE_W + DIGIT_W + 1)'(prefix[j-1])
           * (STRIDE_W + DIGIT_W + 1)'(pos_size[j-1]);
      prefix_next[j] = prod[STRIDE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    prefix <= prefix_next;
  end

  // Stride of each axis: prefix at the first used position naming it
  logic [STRIDE_W-1:0] stride      [MAX_AXES];
  logic [STRIDE_W-1:0] stride_next [MAX_AXES];
  logic                order_err;
  logic                order_err_next;
  always_comb begin
    logic found;
    found = 1'b0;
    order_err_next = 1'b0;
    for (int i = 0; i < MAX_AXES; i++) begin
      found = 1'b0;
      stride_next[i] = '0;
      for (int j = 0; j < MAX_AXES; j++) begin
        if (!found && 3'(j) < n_used && axis_order[2*j +: 2] == 2'(i)) begin
          found = 1'b1;
          stride_next[i] = prefix[j];
        end
      end
      if (3'(i) < n_used && !found) begin
        order_err_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    stride    <= stride_next;
    order_err <= order_err_next;
  end

  // Hold off input until the prefix chain and stride table have caught up
  logic [SETTLE_W-1:0] settle;
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      settle <= SETTLE_W'(MAX_AXES);
    end else if (settle != '0) begin
      settle <= settle - SETTLE_W'(1);
    end
  end

  // --------------------------------------------------------------------------
  // Handshake
  // --------------------------------------------------------------------------
  logic s1_valid;
  logic out_load;
  logic accept;

  assign out_load = !m_tvalid || m_tready;
  assign s_tready = (settle == '0) && (!s1_valid || out_load);
  assign accept   = s_tvalid && s_tready;

  // --------------------------------------------------------------------------
  // Source index: restart, last test, mixed-radix increment, products
  // --------------------------------------------------------------------------
  logic [DIGIT_W-1:0] digits      [MAX_AXES];
  logic [DIGIT_W-1:0] digits_next [MAX_AXES];
  logic [DIGIT_W-1:0] digit_eff   [MAX_AXES];
  logic [TERM_W-1:0]  term_next   [MAX_AXES];
  logic               last_next;

  always_comb begin
    logic carry;
    logic [DIGIT_W-1:0] dmax;
    carry = 1'b1;
    dmax  = '0;
    last_next = 1'b1;
    for (int i = 0; i < MAX_AXES; i++) begin
      digit_eff[i] = s_tuser[0] ? '0 : digits[i];
      dmax = dim_sizes[DIGIT_W*i +: DIGIT_W];
      if (3'(i) < n_used && digit_eff[i] < dmax) begin
        last_next = 1'b0;
      end
      term_next[i] = (3'(i) < n_used) ? TERM_W'(digit_eff[i]) * TERM_W'(stride[i])
                                      : '0;
    end
    // Ripple the increment; a digit at or above its maximum wraps and carries
    for (int i = 0; i < MAX_AXES; i++) begin
      dmax = dim_sizes[DIGIT_W*i +: DIGIT_W];
      digits_next[i] = digit_eff[i];
      if (last_next) begin
        digits_next[i] = '0;
      end else if (carry && 3'(i) < n_used) begin
        if (digit_eff[i] >= dmax) begin
          digits_next[i] = '0;
        end else begin
          digits_next[i] = digit_eff[i] + DIGIT_W'(1);
          carry = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_AXES; i++) begin
        digits[i] <= '0;
      end
    end else if (accept) begin
      digits <= digits_next;
    end
  end

  // --------------------------------------------------------------------------
  // Product stage
  // --------------------------------------------------------------------------
  logic [TERM_W-1:0]  s1_term [MAX_AXES];
  logic [VALUE_W-1:0] s1_value;
  logic               s1_last;
  logic               s1_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (out_load) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_term  <= term_next;
      s1_value <= s_tdata[VALUE_W-1:0];
      s1_last  <= last_next;
      s1_err   <= order_err;
    end
  end

  // --------------------------------------------------------------------------
  // Result stage: sum the products, drop the address on an order error
  // --------------------------------------------------------------------------
  logic [ADDR_W-1:0]  addr_sum;
  logic [ADDR_W-1:0]  dest_address;
  logic [VALUE_W-1:0] value;
  logic               last;
  logic               order_error;

  always_comb begin
    addr_sum = '0;
    for (int i = 0; i < MAX_AXES; i++) begin
      addr_sum = addr_sum + ADDR_W'(s1_term[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (out_load) begin
      m_tvalid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && s1_valid) begin
      dest_address <= s1_err ? '0 : addr_sum;
      value        <= s1_value;
      last         <= s1_last;
      order_error  <= s1_err;
    end
  end

  assign m_tdata = {ELEMENT_FIELD_W'(value), dest_address};
  assign m_tlast = last;
  assign m_tuser = order_error;

endmodule

[design/ttag_checker.sv]
// ----------------------------------------------------------------------------
// ttag_checker
// Port-level checks of the transpose address generator, bound to the top.
// ----------------------------------------------------------------------------
module ttag_checker
  import ttag_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tready,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [M_TDATA_W-1:0] m_tdata,
  input logic                 m_tlast,
  input logic [0:0]           m_tuser,
  input logic                 psel,
  input logic                 penable,
  input logic                 pwrite
);

  // Hold a stalled result request
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
                              && $stable(m_tuser))
    else $error("stalled result changed");

  // An order error forces the address to zero
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> m_tdata[ADDR_W-1:0] == '0)
    else $error("order error with nonzero address");

  // Drop input ready while the stride table reloads after a register write
  assert property (@(posedge clk) disable iff (rst)
    psel && penable && pwrite |=> !s_tready)
    else $error("input accepted right after a register write");

  // Drop input ready while the stride table reloads after reset
  assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready right after reset");

endmodule

bind tensor_transpose_address_gen ttag_checker u_ttag_checker (.*);
